[design/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[design/toht_pkg.sv]
// ----------------------------------------------------------------------------
// toht_pkg
// types and constants, including the set hash mix constants, of the occlusion history table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package toht_pkg;
  localparam int TableSets = 256;
  localparam int TableWays = 4;
  localparam int SetW = (TableSets > 1) ? $clog2(TableSets) : 1;
  localparam int WayW = (TableWays > 1) ? $clog2(TableWays) : 1;
  localparam logic [7:0] RunMax = 8'd255;
  localparam logic [7:0] ThreshReset = 8'd2;
  localparam logic [63:0] MixA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixB = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_SUBMIT = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_EVAL,
    ST_CLEAR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] view;
    logic [63:0] obj;
    logic [31:0] last_frame;
    logic occluded;
    logic [7:0] run;
  } entry_t;

  typedef struct packed {
    logic entry_found;
    logic conservatively_occluded;
    logic [7:0] run_length;
  } result_t;
endpackage
`default_nettype wire

[design/toht_hash.sv]
// ----------------------------------------------------------------------------
// toht_hash
// pipelined splitmix64 finalizer, six register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module toht_hash (
  input wire clk,
  input wire [31:0] view,
  input wire [63:0] obj,
  output logic [toht_pkg::SetW-1:0] set_idx
);
  import toht_pkg::*;
  logic [63:0] s0, s1, s2, s3, s4;
  logic [31:0] pa, pb, pc, pd;
  logic [63:0] h0;
  always_comb begin
    h0 = obj ^ {view, 32'd0};
  end
  // 64x64 multiply truncated to 64 bits, split in two registered steps
  always_ff @(posedge clk) begin
    s0 <= h0 ^ (h0 >> 30);
    pa <= s0[31:0] * MixA[63:32] + s0[63:32] * MixA[31:0];
    s1 <= 64'(s0[31:0]) * 64'(MixA[31:0]);
    s2 <= {s1[63:32] + pa, s1[31:0]};
    s3 <= s2 ^ (s2 >> 27);
    pb <= s3[31:0] * MixB[63:32] + s3[63:32] * MixB[31:0];
    s4 <= 64'(s3[31:0]) * 64'(MixB[31:0]);
    pc <= s4[63:32] + pb;
    pd <= s4[31:0];
  end
  logic [63:0] hf;
  always_comb begin
    hf = {pc, pd};
    hf = hf ^ (hf >> 31);
    set_idx = hf[SetW-1:0];
  end
endmodule
`default_nettype wire

[design/toht_store.sv]
// ----------------------------------------------------------------------------
// toht_store
// set memory with registered read and a valid memory cleared one set a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module toht_store (
  input wire clk,
  input wire rst,
  input wire clear,
  input wire [toht_pkg::SetW-1:0] rd_set,
  output toht_pkg::entry_t rd_data [toht_pkg::TableWays],
  output logic [toht_pkg::TableWays-1:0] rd_valid,
  output logic busy,
  input wire wr_en,
  input wire [toht_pkg::SetW-1:0] wr_set,
  input wire [toht_pkg::WayW-1:0] wr_way,
  input toht_pkg::entry_t wr_data
);
  import toht_pkg::*;
  entry_t mem [TableWays][TableSets];
  logic [TableWays-1:0] vld [TableSets];
  logic [SetW-1:0] clr_set;
  always_ff @(posedge clk) begin
    for (int w = 0; w < TableWays; w++) begin
      rd_data[w] <= mem[w][rd_set];
    end
    if (wr_en) mem[wr_way][wr_set] <= wr_data;
  end
  // rd_valid still holds the valid bits of the set being written
  always_ff @(posedge clk) begin
    if (busy) begin
      vld[clr_set] <= '0;
    end else if (wr_en) begin
      vld[wr_set] <= rd_valid | (TableWays'(1) << wr_way);
    end
    rd_valid <= vld[rd_set];
  end
  // clearing pass over all sets after reset and on clear
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy <= 1'b1;
      clr_set <= '0;
    end else if (busy) begin
      clr_set <= clr_set + SetW'(1);
      if (clr_set == SetW'(TableSets - 1)) busy <= 1'b0;
    end
  end
  `ASSERT_IMPL(a_no_wr_busy, clk, rst, !(wr_en && busy), "write during clearing pass")
  `ASSERT_IMPL(a_pass_ends, clk, rst, busy && !clear && clr_set == SetW'(TableSets - 1) |=> !busy, "clearing pass overran")
  `ASSERT_NORST(a_rst_busy, clk, rst |=> busy, "no clearing pass after reset")
endmodule
`default_nettype wire

[design/temporal_occlusion_history_table_top.sv]
// ----------------------------------------------------------------------------
// temporal_occlusion_history_table_top
// per view and object occlusion history in a hashed set-associative table
// ----------------------------------------------------------------------------
// One request at a time. Submit and query pass through the hash pipeline, the
// set read from the table memory and a step that evaluates and writes back
// before the response is presented. Begin frame passes through the clear state
// before it responds. The next request is taken once the response is accepted
// and the block is idle again with no clearing pass running. After reset and
// after a begin frame with a scene cut the valid bits are cleared one set per
// cycle, and no request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module temporal_occlusion_history_table_top (
  input wire clk,
  input wire rst,
  input wire cfg_we,
  input wire [7:0] cfg_wdata,
  input wire s_axis_tvalid,
  output logic s_axis_tready,
  // cmd[1:0]
  input wire [1:0] s_axis_tuser,
  // frame_number[31:0], scene_cut[32], view_ident[64:33],
  // object_key[128:65], was_occluded[129], zero fill to 136
  input wire [135:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input wire m_axis_tready,
  // entry_found[0], conservatively_occluded[1], run_length[9:2], zero fill
  output logic [15:0] m_axis_tdata
);
  import toht_pkg::*;
  state_t state, state_next;
  logic [7:0] thresh;
  logic [31:0] cur_frame;
  logic [1:0] r_cmd;
  logic [31:0] r_set_frame;
  logic [31:0] r_view;
  logic [63:0] r_obj;
  logic r_occ;
  logic [2:0] cnt;
  result_t res, res_next;
  logic [SetW-1:0] set_idx, r_set;
  entry_t rd_data [TableWays];
  logic [TableWays-1:0] rd_valid;
  logic wr_en, clear, busy;
  logic [WayW-1:0] wr_way;
  entry_t wr_data;
  logic acc;

  assign acc = s_axis_tvalid && s_axis_tready;
  toht_hash u_hash (.clk, .view(r_view), .obj(r_obj), .set_idx);
  toht_store u_store (.clk, .rst, .clear, .rd_set(set_idx), .rd_data, .rd_valid, .busy,
    .wr_en, .wr_set(r_set), .wr_way, .wr_data);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc) begin
        state_next = (cmd_t'(s_axis_tuser) == CMD_SUBMIT ||
          cmd_t'(s_axis_tuser) == CMD_QUERY) ? ST_HASH : ST_CLEAR;
      end
      ST_HASH: if (cnt == 3'd5) state_next = ST_READ;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: state_next = ST_OUT;
      ST_CLEAR: state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic hit;
  logic [WayW-1:0] hway, vway;
  logic have_inv;
  logic [31:0] best_age, age;
  entry_t he;
  logic [7:0] run;
  always_comb begin
    hit = 1'b0; hway = '0; have_inv = 1'b0; vway = '0; best_age = '0;
    for (int w = TableWays - 1; w >= 0; w--) begin
      if (rd_valid[w] && rd_data[w].view == r_view && rd_data[w].obj == r_obj) begin
        hit = 1'b1; hway = WayW'(w);
      end
    end
    for (int w = TableWays - 1; w >= 0; w--) begin
      if (!rd_valid[w]) begin
        have_inv = 1'b1; vway = WayW'(w);
      end
    end
    if (!have_inv) begin
      for (int w = 0; w < TableWays; w++) begin
        age = cur_frame - rd_data[w].last_frame;
        if (w == 0 || age > best_age) begin
          best_age = age; vway = WayW'(w);
        end
      end
    end
    age = '0;
    he = rd_data[hway];
    if (!r_occ) run = 8'd0;
    else if (hit && he.last_frame + 32'd1 == cur_frame)
      run = (he.run == RunMax) ? RunMax : he.run + 8'd1;
    else run = 8'd1;
  end

  always_comb begin
    wr_en = 1'b0; clear = 1'b0; wr_way = hit ? hway : vway;
    wr_data = '{view: r_view, obj: r_obj, last_frame: cur_frame,
      occluded: r_occ, run: run};
    res_next = res;
    s_axis_tready = (state == ST_IDLE) && !busy;
    m_axis_tvalid = (state == ST_OUT);
    case (state)
      ST_EVAL: begin
        if (cmd_t'(r_cmd) == CMD_SUBMIT) begin
          wr_en = 1'b1;
          res_next = '{entry_found: 1'b0, conservatively_occluded: 1'b0, run_length: run};
        end else if (hit) begin
          res_next = '{entry_found: 1'b1,
            conservatively_occluded: he.last_frame == cur_frame && he.occluded &&
              he.run >= thresh,
            run_length: he.run};
        end else res_next = '0;
      end
      ST_CLEAR: begin
        clear = (cmd_t'(r_cmd) == CMD_BEGIN) && r_occ;
        res_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; thresh <= ThreshReset; cur_frame <= '0; cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) thresh <= cfg_wdata;
      cnt <= (state == ST_HASH) ? cnt + 3'd1 : 3'd0;
      if (state == ST_CLEAR && cmd_t'(r_cmd) == CMD_BEGIN) cur_frame <= r_set_frame;
    end
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      r_cmd <= s_axis_tuser;
      r_set_frame <= s_axis_tdata[31:0];
      r_view <= s_axis_tdata[64:33];
      r_obj <= s_axis_tdata[128:65];
      r_occ <= (cmd_t'(s_axis_tuser) == CMD_BEGIN) ? s_axis_tdata[32]
        : s_axis_tdata[129];
    end
    if (state == ST_READ) r_set <= set_idx;
    res <= res_next;
  end
  assign m_axis_tdata = {6'd0, res.run_length, res.conservatively_occluded, res.entry_found};

  `ASSERT_IMPL(a_one_side, clk, rst, !(s_axis_tready && m_axis_tvalid), "overlap")
  `ASSERT_IMPL(a_wr_eval, clk, rst, wr_en |-> state == ST_EVAL, "stray write")
  `ASSERT_IMPL(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
    "result dropped")
endmodule
`default_nettype wire
